>>> sv/sparse_table_range_max_assert.svh
// Assertion macros for the range-maximum engine.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef SPARSE_TABLE_RANGE_MAX_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MAX_ASSERT_SVH
`ifndef SYNTHESIS
`define SRMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRMQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRMQ_ASSERT(lbl, prop, msg)
`define SRMQ_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/srmq_pkg.sv
`default_nettype none
package srmq_pkg;

    // Default sizes of the table.
    localparam int DEPTH_DEF   = 1024;
    localparam int LEVELS_DEF  = 11;
    localparam int VALUE_W_DEF = 32;

    // Fixed field widths of the stream items and the count register.
    localparam int CMD_W      = 2;
    localparam int POS_W      = 10;
    localparam int COUNT_W    = 11;
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = ((2 * POS_W + DATA_W + 7) / 8) * 8;
    localparam int LOG_W      = $clog2(COUNT_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic query_rd;
        logic build_init;
        logic build_rd;
        logic build_wr;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic build_more;
    } stat_t;

    // Priority encoder: index of the highest set bit of a nonzero length.
    function automatic logic [LOG_W-1:0] floor_log2(input logic [COUNT_W-1:0] len);
        logic [LOG_W-1:0] k;
        k = '0;
        for (int b = 0; b < COUNT_W; b++)
        begin
            if (len[b])
            begin
                k = LOG_W'(b);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

>>> sv/srmq_ctrl.sv
`default_nettype none
module srmq_ctrl
    import srmq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [CMD_W-1:0] in_command,
    input  wire logic             out_ready,
    input  wire stat_t            stat,
    output logic                  in_ready,
    output logic                  out_valid,
    output cmd_t                  cmd
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_QUERY    = 2'd1;
    localparam logic [1:0] ST_BUILD_RD = 2'd2;
    localparam logic [1:0] ST_BUILD_WR = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_command)
                        CMD_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                        end
                        CMD_BUILD:
                        begin
                            cmd.build_init = 1'b1;
                            state_next     = ST_BUILD_RD;
                        end
                        CMD_QUERY:
                        begin
                            cmd.query_rd = 1'b1;
                            state_next   = ST_QUERY;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BUILD_RD:
            begin
                if (stat.build_more)
                begin
                    cmd.build_rd = 1'b1;
                    state_next   = ST_BUILD_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BUILD_WR:
            begin
                cmd.build_wr = 1'b1;
                state_next   = ST_BUILD_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed transfers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> sv/srmq_datapath.sv
`default_nettype none
module srmq_datapath
    import srmq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [COUNT_W-1:0]  cfg_wr_data,
    input  wire logic [POS_W-1:0]    in_position,
    input  wire logic [POS_W-1:0]    in_right_end,
    input  wire logic [DATA_W-1:0]   in_value,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    output logic [DATA_W-1:0]        max_value,
    output logic                     status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int LA_W  = $clog2(LEVELS);
    localparam int LV_W  = $clog2(LEVELS + 1);
    localparam int WW    = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam int AW    = LA_W + IDX_W;
    localparam int WORDS = LEVELS << IDX_W;

    // Control state.
    logic [COUNT_W-1:0] count_reg;
    logic               built_reg;
    logic [LV_W-1:0]    lvl_reg;
    logic [WW-1:0]      j_reg;

    // Payload registers.
    logic [VALUE_WIDTH-1:0] table_mem [0:WORDS-1];
    logic [VALUE_WIDTH-1:0] rd_a_reg;
    logic [VALUE_WIDTH-1:0] rd_b_reg;
    logic                   err_reg;
    logic [DATA_W-1:0]      max_value_reg;
    logic                   status_reg;

    logic [WW-1:0]          n;
    logic [WW-1:0]          pos_w;
    logic [WW-1:0]          right_w;
    logic                   q_err;
    logic [COUNT_W-1:0]     len;
    logic [LOG_W-1:0]       k_raw;
    logic [LA_W-1:0]        k_cl;
    logic [WW-1:0]          q_b_idx;
    logic [WW-1:0]          span;
    logic [WW-1:0]          half;
    logic [WW-1:0]          j_half;
    logic                   lvl_ok;
    logic [LA_W-1:0]        lvl_prev;
    logic [VALUE_WIDTH-1:0] pair_max;
    logic [VALUE_WIDTH+DATA_W-1:0] val_wide;
    logic [DATA_W+VALUE_WIDTH-1:0] max_wide;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic                   rd_en;
    logic [AW-1:0]          mem_ra;
    logic [AW-1:0]          mem_rb;

    // Covered element count, capped to the table depth.
    assign n = (WW'(count_reg) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(count_reg);

    // Query checks and block placement.
    assign pos_w   = WW'(in_position);
    assign right_w = WW'(in_right_end);
    assign q_err   = !built_reg || (in_position > in_right_end) || (right_w >= n);
    assign len     = COUNT_W'(in_right_end) - COUNT_W'(in_position) + COUNT_W'(1);
    assign k_raw   = floor_log2(len);

    always_comb
    begin
        if (int'(k_raw) > LEVELS - 1)
        begin
            k_cl = LA_W'(LEVELS - 1);
        end
        else
        begin
            k_cl = LA_W'(k_raw);
        end
    end

    assign q_b_idx = right_w + WW'(1) - (WW'(1) << k_cl);

    // Build sweep: level lvl_reg, entry j_reg.
    assign span     = WW'(1) << lvl_reg;
    assign half     = span >> 1;
    assign j_half   = j_reg + half;
    assign lvl_ok   = (int'(lvl_reg) <= IDX_W) && (int'(lvl_reg) < LEVELS);
    assign lvl_prev = LA_W'(lvl_reg - LV_W'(1));
    assign stat.build_more = lvl_ok && (span <= n);

    // Signed maximum of the two registered reads.
    assign pair_max = ($signed(rd_a_reg) > $signed(rd_b_reg)) ? rd_a_reg : rd_b_reg;

    // Value width conversion in and out.
    assign val_wide = {VALUE_WIDTH'(0), in_value};
    assign max_wide = {DATA_W'(0), pair_max};

    // Memory port selection.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = {LA_W'(0), pos_w[IDX_W-1:0]};
        mem_wd = val_wide[VALUE_WIDTH-1:0];
        if (cmd.build_wr)
        begin
            mem_we = 1'b1;
            mem_wa = {LA_W'(lvl_reg), j_reg[IDX_W-1:0]};
            mem_wd = pair_max;
        end
        else if (cmd.load_wr)
        begin
            mem_we = (pos_w < WW'(DEPTH));
        end
    end

    assign rd_en  = cmd.query_rd || cmd.build_rd;
    assign mem_ra = cmd.build_rd ? {lvl_prev, j_reg[IDX_W-1:0]}
                                 : {k_cl, pos_w[IDX_W-1:0]};
    assign mem_rb = cmd.build_rd ? {lvl_prev, j_half[IDX_W-1:0]}
                                 : {k_cl, q_b_idx[IDX_W-1:0]};

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_a_reg <= table_mem[mem_ra];
            rd_b_reg <= table_mem[mem_rb];
        end
    end

    // Count register, built flag and build counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            built_reg <= 1'b0;
            lvl_reg   <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
                built_reg <= 1'b0;
            end
            if (cmd.load_wr)
            begin
                built_reg <= 1'b0;
            end
            if (cmd.build_init)
            begin
                built_reg <= 1'b1;
                lvl_reg   <= LV_W'(1);
                j_reg     <= '0;
            end
            if (cmd.build_wr)
            begin
                if (j_reg + span >= n)
                begin
                    lvl_reg <= lvl_reg + LV_W'(1);
                    j_reg   <= '0;
                end
                else
                begin
                    j_reg <= j_reg + WW'(1);
                end
            end
        end
    end

    // Query error flag and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.query_rd)
        begin
            err_reg <= q_err;
        end
        if (cmd.out_load)
        begin
            max_value_reg <= err_reg ? '0 : max_wide[DATA_W-1:0];
            status_reg    <= err_reg;
        end
    end

    assign max_value = max_value_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

>>> sv/sparse_table_range_max.sv
// Load: one item per cycle, no result. Query: the input is held until its result is loaded;
// both table reads finish at the input transfer, the compared result enters the output
// register as the query state returns to idle, and the next item is taken in idle. While an
// earlier result still waits in the output register, a query stays in its query state.
// Build: each table entry above level 0 that it writes is read in the build-read state and
// written in the build-write state, both on the shared table memory.
// rst_n is asynchronous and active low: it empties the output, clears the built flag and sets
// the element count to 1. Table contents are undefined until loaded or built.
`default_nettype none
`include "sparse_table_range_max_assert.svh"
module sparse_table_range_max
    import srmq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [COUNT_W-1:0]    cfg_wr_data,    // element_count
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,   // position, right_end, value
    input  wire logic [CMD_W-1:0]      s_axis_tuser,   // command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DATA_W-1:0]          m_axis_tdata,   // max_value
    output logic                       m_axis_tuser    // status
);

    cmd_t  cmd;
    stat_t stat;

    // Controller state machine.
    srmq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .out_ready  (m_axis_tready),
        .stat       (stat),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .cmd        (cmd)
    );

    // Table memory, build counters and query logic.
    srmq_datapath #(
        .DEPTH       (DEPTH),
        .LEVELS      (LEVELS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_position  (s_axis_tdata[POS_W-1:0]),
        .in_right_end (s_axis_tdata[2*POS_W-1:POS_W]),
        .in_value     (s_axis_tdata[2*POS_W+DATA_W-1:2*POS_W]),
        .cmd          (cmd),
        .stat         (stat),
        .max_value    (m_axis_tdata),
        .status       (m_axis_tuser)
    );

    // A query holds off the input in the cycle after its transfer.
    `SRMQ_ASSERT(a_query_busy,
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY) |=> !s_axis_tready,
        "query transfer did not stall the input")
    // A build always leaves the idle state for its sweep.
    `SRMQ_ASSERT(a_build_busy,
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_BUILD) |=> !s_axis_tready,
        "build transfer did not stall the input")
    // A load completes in its own cycle.
    `SRMQ_ASSERT(a_load_single,
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD) |=> s_axis_tready,
        "load transfer stalled the input")
    // An error result always carries a zero maximum.
    `SRMQ_NEVER(a_err_zero,
        m_axis_tvalid && m_axis_tuser && (m_axis_tdata != '0),
        "error result with nonzero max_value")

endmodule
`default_nettype wire

>>> tb/range_max_scoreboard_pkg.sv
package range_max_scoreboard_pkg;
    import srmq_pkg::*;

    localparam int TAB_DEPTH  = DEPTH_DEF;
    localparam int TAB_LEVELS = LEVELS_DEF;

    // The one command code the block has to ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] max_value;
        logic              status;
    } range_result_t;

    class range_max_scoreboard;
        logic signed [DATA_W-1:0] level_max [TAB_LEVELS][TAB_DEPTH];
        bit                       table_ready;
        logic [COUNT_W-1:0]       elem_count;
        range_result_t            expected_q[$];
        int                       mismatches;
        int                       loads;
        int                       builds;
        int                       good_queries;
        int                       error_queries;
        int                       results_seen;

        function new();
            foreach (level_max[i, j])
            begin
                level_max[i][j] = '0;
            end
            table_ready   = 1'b0;
            elem_count    = COUNT_W'(1);
            mismatches    = 0;
            loads         = 0;
            builds        = 0;
            good_queries  = 0;
            error_queries = 0;
            results_seen  = 0;
        endfunction

        // Number of positions that builds and queries cover, capped at the depth.
        function int covered();
            return (elem_count > TAB_DEPTH) ? TAB_DEPTH : int'(elem_count);
        endfunction

        // Any write of the count drops the table.
        function void note_config(input logic [COUNT_W-1:0] count);
            elem_count  = count;
            table_ready = 1'b0;
        endfunction

        // Updates the table for an accepted input transfer and queues the answer of a query.
        function void note_input(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [POS_W-1:0] right, input logic [DATA_W-1:0] val);
            int n;
            int p;
            int q;
            int k;
            int len;
            int span;
            logic signed [DATA_W-1:0] lo_half;
            logic signed [DATA_W-1:0] hi_half;
            range_result_t res;
            n = covered();
            p = int'(pos);
            q = int'(right);
            case (cmd)
                CMD_LOAD:
                begin
                    if (p < TAB_DEPTH)
                    begin
                        level_max[0][p] = val;
                    end
                    table_ready = 1'b0;
                    loads++;
                end
                CMD_BUILD:
                begin
                    // Each level keeps the larger of two half-width entries below it.
                    for (int i = 1; i < TAB_LEVELS && (1 << i) <= n; i++)
                    begin
                        span = 1 << i;
                        for (int j = 0; j + span <= n; j++)
                        begin
                            lo_half = level_max[i-1][j];
                            hi_half = level_max[i-1][j + span / 2];
                            level_max[i][j] = (lo_half > hi_half) ? lo_half : hi_half;
                        end
                    end
                    table_ready = 1'b1;
                    builds++;
                end
                CMD_QUERY:
                begin
                    if (!table_ready || p > q || q >= n)
                    begin
                        res.max_value = '0;
                        res.status    = 1'b1;
                        error_queries++;
                    end
                    else
                    begin
                        // Two overlapping blocks of the largest power of two within the range.
                        len = q - p + 1;
                        k   = 0;
                        while (k < TAB_LEVELS - 1 && (len >> (k + 1)) != 0)
                        begin
                            k++;
                        end
                        lo_half = level_max[k][p];
                        hi_half = level_max[k][q + 1 - (1 << k)];
                        res.max_value = (lo_half > hi_half) ? lo_half : hi_half;
                        res.status    = 1'b0;
                        good_queries++;
                    end
                    expected_q.push_back(res);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        // Compares one result transfer with the oldest queued answer.
        task check_result(input logic [DATA_W-1:0] max_value, input logic status);
            range_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result with no query waiting: max %0d status %0b",
                                          $signed(max_value), status));
                return;
            end
            want = expected_q.pop_front();
            if (max_value !== want.max_value)
            begin
                report_mismatch($sformatf("result %0d: max_value %0d, predicted %0d",
                                          results_seen, $signed(max_value),
                                          $signed(want.max_value)));
            end
            if (status !== want.status)
            begin
                report_mismatch($sformatf("result %0d: status %0b, predicted %0b",
                                          results_seen, status, want.status));
            end
        endtask
    endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srmq_pkg::*;
    import range_max_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PRESSURE_AFTER  = 150;
    localparam int PRESSURE_CYCLES = 400;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]    cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;

    range_max_scoreboard sb;
    bit                  loaded_pos [TAB_DEPTH];
    bit                  steady_flow   = 1'b0;
    bit                  pressure_done = 1'b0;
    int                  idle_cycles   = 0;
    int                  items_sent    = 0;
    int                  configs_written = 0;
    int                  phases_run    = 0;

    sparse_table_range_max dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),     // element_count
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // position, right_end, value
        .s_axis_tuser  (s_axis_tuser),    // command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // max_value
        .m_axis_tuser  (m_axis_tuser)     // status
    );

    // Free-running clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Every accepted result transfer goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // The run ends when nothing has moved on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off that backs up the block.
    initial
    begin : result_sink
        int hold_left;
        int r;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && sb.results_seen >= PRESSURE_AFTER)
            begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!steady_flow)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                    begin
                        hold_left = $urandom_range(10, 50);
                    end
                    else if (r < 20)
                    begin
                        hold_left = $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    // Offers one item after a random gap and waits for its transfer.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] right, input logic [DATA_W-1:0] val);
        int gap;
        int r;
        gap = 0;
        if (!steady_flow)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
            begin
                gap = $urandom_range(8, 40);
            end
            else if (r >= 65)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({val, right, pos});
        s_axis_tuser  <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_input(cmd, pos, right, val);
        if (cmd == CMD_LOAD)
        begin
            loaded_pos[pos] = 1'b1;
        end
        items_sent++;
    endtask

    // Drops valid and waits until every query has been answered and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] count);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.note_config(count);
        configs_written++;
    endtask

    // Values lean toward the signed extremes, zero and minus one.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // A build only ever covers loaded positions, so any gap is loaded first.
    task automatic send_build();
        int n;
        n = sb.covered();
        for (int p = 0; p < n; p++)
        begin
            if (!loaded_pos[p])
            begin
                send_item(CMD_LOAD, POS_W'(p), POS_W'($urandom), pick_value());
            end
        end
        send_item(CMD_BUILD, POS_W'($urandom), POS_W'($urandom), $urandom);
    endtask

    // A query inside the covered range, often one power of two long.
    task automatic send_valid_query(input int n);
        int len;
        int k;
        int left;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            k = 0;
            while ((2 << k) <= n)
            begin
                k++;
            end
            len = 1 << $urandom_range(0, k);
        end
        else if (r < 5)
        begin
            len = n;
        end
        else
        begin
            len = $urandom_range(1, n);
        end
        left = $urandom_range(0, n - len);
        send_item(CMD_QUERY, POS_W'(left), POS_W'(left + len - 1), $urandom);
    endtask

    // A query that is likely to be rejected: any range, one past the end, or empty.
    task automatic send_noise_query(input int n);
        int left;
        int right;
        case ($urandom_range(0, 2))
            0:
            begin
                left  = $urandom_range(0, TAB_DEPTH - 1);
                right = $urandom_range(0, TAB_DEPTH - 1);
            end
            1:
            begin
                right = (n < TAB_DEPTH) ? n : TAB_DEPTH - 1;
                left  = $urandom_range(0, right);
            end
            default:
            begin
                right = $urandom_range(0, TAB_DEPTH - 2);
                left  = $urandom_range(right + 1, TAB_DEPTH - 1);
            end
        endcase
        send_item(CMD_QUERY, POS_W'(left), POS_W'(right), $urandom);
    endtask

    // One setting of the count followed by a random mix that is mostly built-table queries.
    task automatic run_phase(input logic [COUNT_W-1:0] count, input int items);
        int n;
        int r;
        int top;
        wait_idle();
        write_count(count);
        n           = sb.covered();
        steady_flow = (phases_run % 4 == 3);
        top         = (n + 2 < TAB_DEPTH) ? n + 2 : TAB_DEPTH - 1;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ((n > 256) ? 3 : 25))
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    send_item(CMD_LOAD, POS_W'($urandom_range(0, top)), POS_W'($urandom),
                              pick_value());
                end
                else
                begin
                    send_item(CMD_LOAD, POS_W'($urandom), POS_W'($urandom), pick_value());
                end
            end
            else if (r < 32)
            begin
                if (n <= 256 || !sb.table_ready)
                begin
                    send_build();
                end
                else
                begin
                    send_valid_query(n);
                end
            end
            else if (r < 95)
            begin
                if (n > 0 && !sb.table_ready && $urandom_range(0, 9) < 8)
                begin
                    send_build();
                end
                if (n > 0 && $urandom_range(0, 99) < 85)
                begin
                    send_valid_query(n);
                end
                else
                begin
                    send_noise_query(n);
                end
            end
            else
            begin
                send_item(CMD_UNUSED, POS_W'($urandom), POS_W'($urandom), $urandom);
            end
        end
        // Closing with a query means its answer arrives only once any build is done.
        if (n > 0)
        begin
            send_valid_query(n);
        end
        else
        begin
            send_noise_query(n);
        end
        phases_run++;
    endtask

    initial
    begin : stimulus
        logic [COUNT_W-1:0] counts [$];
        sb = new();
        foreach (loaded_pos[p])
        begin
            loaded_pos[p] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset count of one: query before build, a single element, past the end, empty range,
        // and the unused command, which must leave the table built.
        send_item(CMD_QUERY, 10'd0, 10'd0, $urandom);
        send_item(CMD_LOAD, 10'd0, 10'd1023, 32'h8000_0000);
        send_item(CMD_BUILD, 10'd0, 10'd0, 32'd0);
        send_item(CMD_QUERY, 10'd0, 10'd0, $urandom);
        send_item(CMD_QUERY, 10'd0, 10'd1, $urandom);
        send_item(CMD_QUERY, 10'd1, 10'd0, $urandom);
        send_item(CMD_UNUSED, 10'd1023, 10'd1023, 32'hffff_ffff);
        send_item(CMD_QUERY, 10'd0, 10'd0, $urandom);

        // Four elements at the signed extremes; a load between build and query drops the table.
        wait_idle();
        write_count(11'd4);
        send_item(CMD_LOAD, 10'd0, 10'd0, 32'h7fff_ffff);
        send_item(CMD_LOAD, 10'd1, 10'd0, 32'h0000_0000);
        send_item(CMD_LOAD, 10'd2, 10'd0, 32'hffff_ffff);
        send_item(CMD_LOAD, 10'd3, 10'd0, 32'h8000_0000);
        send_item(CMD_BUILD, 10'd0, 10'd0, 32'd0);
        send_item(CMD_QUERY, 10'd0, 10'd3, 32'd0);
        send_item(CMD_QUERY, 10'd1, 10'd3, 32'd0);
        send_item(CMD_QUERY, 10'd2, 10'd3, 32'd0);
        send_item(CMD_LOAD, 10'd1, 10'd0, 32'd5);
        send_item(CMD_QUERY, 10'd0, 10'd1, 32'd0);
        send_item(CMD_BUILD, 10'd0, 10'd0, 32'd0);
        send_item(CMD_QUERY, 10'd1, 10'd2, 32'd0);

        // Rewriting the same count also drops the table.
        wait_idle();
        write_count(11'd4);
        send_item(CMD_QUERY, 10'd0, 10'd3, 32'd0);

        // A count of zero: build only marks the table, every query is rejected.
        wait_idle();
        write_count(11'd0);
        send_item(CMD_BUILD, 10'd0, 10'd0, 32'd0);
        send_item(CMD_QUERY, 10'd0, 10'd0, 32'd0);

        // Random phases over small counts, the full depth and counts beyond it.
        counts = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd16, 11'd17, 11'd31, 11'd32,
                   11'd2047, 11'd64, 11'd100, 11'd1024, 11'd0, 11'd1025, 11'd7};
        counts.push_back(COUNT_W'($urandom_range(1, 200)));
        counts.push_back(COUNT_W'($urandom_range(1, 200)));
        foreach (counts[i])
        begin
            run_phase(counts[i], (counts[i] > 256) ? 50 : 25);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Covered %0d items over %0d random phases and %0d count writes:",
                 items_sent, phases_run, configs_written);
        $display("%0d loads, %0d builds; queries answered with a maximum: %0d, rejected: %0d.",
                 sb.loads, sb.builds, sb.good_queries, sb.error_queries);
        $display("Mismatches: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/srmq_pkg.sv
sv/srmq_ctrl.sv
sv/srmq_datapath.sv
sv/sparse_table_range_max.sv
tb/range_max_scoreboard_pkg.sv
tb/tb_top.sv
